>>> hdl/ccb_pkg.sv
// Package for the clipped color-key blitter.
// Holds the configuration and queue entry types and the register index codes.
// Depends on nothing; every other file but ccb_if.sv refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ccb_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_WIDTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DEST_X       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DEST_Y       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WIN_X        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_WIN_Y        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_WIN_W        = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_WIN_H        = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_COLOR    = 3'd7;

   typedef struct packed {
      logic [11:0] source_width;
      logic [11:0] dest_x;
      logic [11:0] dest_y;
      logic [8:0]  win_x;
      logic [7:0]  win_y;
      logic [8:0]  win_w;
      logic [7:0]  win_h;
      logic [8:0]  key_color;
   } cfg_type;

   typedef struct packed {
      logic       write_enable;
      logic [8:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] pixel;
      logic       last_pixel;
   } entry_type;

endpackage

`default_nettype wire

>>> hdl/ccb_if.sv
// Channel interfaces of the clipped color-key blitter.
// The pixel request channel and the frame-buffer write channel.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ccb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic       last_pixel;

   modport source (output valid, output pixel, output last_pixel, input ready);
   modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

interface ccb_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_enable;
   logic [15:0] write_address;
   logic [7:0]  write_pixel;
   logic        blit_done;

   modport source (output valid, output write_enable, output write_address,
                   output write_pixel, output blit_done, input ready);
   modport sink   (input valid, input write_enable, input write_address,
                   input write_pixel, input blit_done, output ready);
endinterface

`default_nettype wire

>>> hdl/clipped_color_key_blitter_top.sv
// Top level of the clipped color-key blitter: configuration registers,
// front end, queue and back end. Depends on ccb_pkg, ccb_if, ccb_front,
// ccb_queue and ccb_back.
//
//   Port group   Direction   Carries
//   req_chan     in          pixel, last_pixel
//   rsp_chan     out         write_enable, write_address, write_pixel, blit_done
//   csr_*        in          register writes, no read-back
//
// One pixel is taken every clock while the queue has room.
// The front end clips and keys in the cycle of the transfer, the back end forms
// the address with one constant multiply in the cycle it leaves the queue.
// Reset is synchronous and clears the counters, the queue and the result valid.
// A stalled output fills the two-entry queue before the input stalls.
`timescale 1ns / 1ps
`default_nettype none

module clipped_color_key_blitter_top #(
   parameter int SCREEN_W = 320
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [ccb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [ccb_pkg::CSR_DATA_W-1:0]      csr_write_data,
   ccb_req_if.sink                                  req_chan,
   ccb_rsp_if.source                                rsp_chan
);

   ccb_pkg::cfg_type   cfg_ff, cfg_in;
   ccb_pkg::entry_type push_entry;
   ccb_pkg::entry_type pop_entry;
   logic               push_valid;
   logic               push_ready;
   logic               pop_valid;
   logic               pop_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ccb_pkg::REG_SOURCE_WIDTH: cfg_in.source_width = csr_write_data;
            ccb_pkg::REG_DEST_X:       cfg_in.dest_x       = csr_write_data;
            ccb_pkg::REG_DEST_Y:       cfg_in.dest_y       = csr_write_data;
            ccb_pkg::REG_WIN_X:        cfg_in.win_x        = csr_write_data[8:0];
            ccb_pkg::REG_WIN_Y:        cfg_in.win_y        = csr_write_data[7:0];
            ccb_pkg::REG_WIN_W:        cfg_in.win_w        = csr_write_data[8:0];
            ccb_pkg::REG_WIN_H:        cfg_in.win_h        = csr_write_data[7:0];
            ccb_pkg::REG_KEY_COLOR:    cfg_in.key_color    = csr_write_data[8:0];
            default:                   cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width <= 12'd1;
         cfg_ff.dest_x       <= 12'd0;
         cfg_ff.dest_y       <= 12'd0;
         cfg_ff.win_x        <= 9'd0;
         cfg_ff.win_y        <= 8'd0;
         cfg_ff.win_w        <= 9'd320;
         cfg_ff.win_h        <= 8'd200;
         cfg_ff.key_color    <= 9'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ccb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   ccb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   ccb_back #(
      .SCREEN_W (SCREEN_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp       (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("Result valid set right after reset.");

   assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_ready && !(pop_valid && pop_ready)) |=> pop_valid)
      else $error("Queue lost a pushed entry.");

   assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_entry.write_enable) |->
      ({3'b000, pop_entry.pos_x} < {3'b000, cfg_ff.win_w}))
      else $error("Queued write lies outside the window width.");
`endif

endmodule

`default_nettype wire

>>> hdl/ccb_front.sv
// Front end of the blitter: accepts pixels, tracks raster position, clips and keys.
// Depends on ccb_pkg and the request interface in ccb_if.sv.
`timescale 1ns / 1ps
`default_nettype none

module ccb_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ccb_pkg::cfg_type   cfg,
   ccb_req_if.sink                 req,
   output logic                    push_valid,
   input  wire logic               push_ready,
   output ccb_pkg::entry_type      push_entry
);

   logic [11:0] col_ff, col_in;
   logic [11:0] row_ff, row_in;
   logic [13:0] px_sum;
   logic [13:0] py_sum;
   logic        inside_x;
   logic        inside_y;
   logic        opaque;
   logic        accept;

   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign accept     = req.valid && push_ready;

   assign px_sum = {2'b00, col_ff} + {{2{cfg.dest_x[11]}}, cfg.dest_x};
   assign py_sum = {2'b00, row_ff} + {{2{cfg.dest_y[11]}}, cfg.dest_y};

   assign inside_x = !px_sum[13] && (px_sum[12:0] < {4'b0000, cfg.win_w});
   assign inside_y = !py_sum[13] && (py_sum[12:0] < {5'b00000, cfg.win_h});
   assign opaque   = {1'b0, req.pixel} != cfg.key_color;

   always_comb begin
      push_entry.write_enable = inside_x && inside_y && opaque;
      push_entry.pos_x        = px_sum[8:0];
      push_entry.pos_y        = py_sum[7:0];
      push_entry.pixel        = req.pixel;
      push_entry.last_pixel   = req.last_pixel;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (req.last_pixel) begin
            col_in = '0;
            row_in = '0;
         end else if ({1'b0, col_ff} + 13'd1 >= {1'b0, cfg.source_width}) begin
            col_in = '0;
            if (row_ff != 12'hFFF) begin
               row_in = row_ff + 12'd1;
            end
         end else begin
            col_in = col_ff + 12'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/ccb_queue.sv
// Two-entry queue between the front end and the address back end.
// Depends on ccb_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module ccb_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire ccb_pkg::entry_type  push_entry,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output ccb_pkg::entry_type       pop_entry
);

   ccb_pkg::entry_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> hdl/ccb_back.sv
// Back end of the blitter: forms the frame-buffer address and holds the result.
// Depends on ccb_pkg and the response interface in ccb_if.sv.
`timescale 1ns / 1ps
`default_nettype none

module ccb_back #(
   parameter int SCREEN_W = 320
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ccb_pkg::cfg_type    cfg,
   input  wire logic                pop_valid,
   output logic                     pop_ready,
   input  wire ccb_pkg::entry_type  pop_entry,
   ccb_rsp_if.source                rsp
);

   logic        valid_ff, valid_in;
   logic        we_ff;
   logic [15:0] addr_ff;
   logic [7:0]  pixel_ff;
   logic        done_ff;
   logic [8:0]  screen_row;
   logic [15:0] row_base;
   logic [15:0] screen_col;
   logic [15:0] addr_in;

   assign pop_ready = !valid_ff || rsp.ready;

   assign screen_row = {1'b0, cfg.win_y} + {1'b0, pop_entry.pos_y};
   assign row_base   = 16'(32'(screen_row) * SCREEN_W);
   assign screen_col = 16'(cfg.win_x) + 16'(pop_entry.pos_x);
   assign addr_in    = pop_entry.write_enable ? row_base + screen_col : 16'd0;

   always_comb begin
      valid_in = valid_ff;
      if (pop_ready) begin
         valid_in = pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         we_ff    <= pop_entry.write_enable;
         addr_ff  <= addr_in;
         pixel_ff <= pop_entry.write_enable ? pop_entry.pixel : 8'd0;
         done_ff  <= pop_entry.last_pixel;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.write_enable  = we_ff;
   assign rsp.write_address = addr_ff;
   assign rsp.write_pixel   = pixel_ff;
   assign rsp.blit_done     = done_ff;

endmodule

`default_nettype wire
